// File: rtl/lobm_pkg.sv
// Package for the limit order book matcher: message kinds, status codes
// and the resting-order record type. No dependencies.
`timescale 1ns / 1ps
package lobm_pkg;
   localparam logic [1:0] KIND_NEW    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_MODIFY = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_ID    = 2'd1;
   localparam logic [1:0] STATUS_BOOK_FULL = 2'd2;

   localparam int SLOT_BITS = 1 + 32 + 32 + 32 + 64;

   typedef struct packed {
      logic        side;
      logic [31:0] oid;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [63:0] arrival;
   } slot_type;
endpackage

// File: rtl/lobm_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/limit_order_book_matcher_core.sv
// Limit order book matcher: price-time priority over a slot table in RAM.
// Each table scan reads every slot through the single RAM read port. A cancel
// costs one scan, each trade one scan plus a fill step and an output step, and a remainder
// one scan that finds no match plus a rest step; the completion item comes after that.
// The input stalls until that item is taken. Synchronous reset
// empties the book and zeroes the arrival counter; the slot RAM is not cleared.
`timescale 1ns / 1ps
module limit_order_book_matcher_core #(
   parameter int ORDER_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_order_id,
   input  logic        req_side,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   input  logic [63:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_completion,
   output logic [31:0] rsp_trade_price,
   output logic [31:0] rsp_trade_quantity,
   output logic [31:0] rsp_buy_id,
   output logic [31:0] rsp_sell_id,
   output logic [63:0] rsp_trade_time,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import lobm_pkg::*;

   localparam int AW = $clog2(ORDER_SLOTS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] LAST_IDX = CW'(ORDER_SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CANCEL = 3'd1;
   localparam logic [2:0] ST_MATCH  = 3'd2;
   localparam logic [2:0] ST_FILL   = 3'd3;
   localparam logic [2:0] ST_REST   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  kind_ff;
   logic [31:0] id_ff, price_ff, left_ff;
   logic        side_ff;
   logic [63:0] ts_ff, arrival_ff;
   logic [1:0]  status_ff;
   logic [CW-1:0] ntrades_ff;
   logic [ORDER_SLOTS-1:0] valid_ff;
   logic [CW-1:0] scan_ff;        // address issued this cycle
   logic          rd_live_ff;     // read data valid this cycle
   logic [AW-1:0] rd_idx_ff;
   logic          found_ff;
   logic [AW-1:0] best_idx_ff;
   slot_type      best_ff;
   logic          after_out_done_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   slot_type      wr_data, rd_data;

   lobm_ram #(.WIDTH(SLOT_BITS), .DEPTH(ORDER_SLOTS)) u_slots (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_addr   = scan_ff[AW-1:0];
   assign req_stall = (state_ff != ST_IDLE);

   // Candidate test for the entry whose read data is live.
   logic cand_valid, cand_cross, cand_better, cancel_hit;
   logic [31:0] take_qty;
   logic        free_found;
   logic [AW-1:0] free_idx;
   always_comb begin
      cand_valid = rd_live_ff && valid_ff[rd_idx_ff];
      cand_cross = (rd_data.side != side_ff) &&
                   (side_ff ? (rd_data.price >= price_ff) : (rd_data.price <= price_ff));
      cand_better = !found_ff ||
                    (side_ff ? (rd_data.price > best_ff.price) : (rd_data.price < best_ff.price)) ||
                    (rd_data.price == best_ff.price && rd_data.arrival < best_ff.arrival);
      cancel_hit = cand_valid && rd_data.oid == id_ff &&
                   (!found_ff || rd_data.arrival < best_ff.arrival);
      take_qty = (left_ff < best_ff.quantity) ? left_ff : best_ff.quantity;
      free_found = 1'b0;
      free_idx = '0;
      for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   logic scan_end;
   assign scan_end = rd_live_ff && (rd_idx_ff == LAST_IDX[AW-1:0]);

   always_comb begin
      wr_en = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_ff;
      if (state_ff == ST_FILL) begin
         wr_en = 1'b1;
         wr_data.quantity = best_ff.quantity - take_qty;
      end else if (state_ff == ST_REST) begin
         wr_en = free_found;
         wr_addr = free_idx;
         wr_data.side = side_ff;
         wr_data.oid = id_ff;
         wr_data.price = price_ff;
         wr_data.quantity = left_ff;
         wr_data.arrival = arrival_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   ;
         ST_CANCEL: if (scan_end) state_in = ST_IDLE;
         ST_MATCH:  if (scan_end) state_in = ST_IDLE;
         ST_FILL:   state_in = ST_OUT;
         ST_REST:   state_in = ST_DONE;
         ST_DONE:   state_in = ST_OUT;
         ST_OUT:    ;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         arrival_ff <= '0;
         rsp_valid <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= 1'b0;
         rd_idx_ff <= scan_ff[AW-1:0];
         if (scan_ff <= LAST_IDX &&
             (state_ff == ST_CANCEL || state_ff == ST_MATCH)) begin
            rd_live_ff <= 1'b1;
            scan_ff <= scan_ff + 1'b1;
         end
         case (state_ff)
            ST_IDLE: if (req_valid) begin
               kind_ff <= req_kind; id_ff <= req_order_id; side_ff <= req_side;
               price_ff <= req_price; left_ff <= req_quantity;
               ts_ff <= req_timestamp; status_ff <= STATUS_OK;
               ntrades_ff <= '0; scan_ff <= '0; found_ff <= 1'b0;
               if (req_kind == KIND_CANCEL || req_kind == KIND_MODIFY)
                  state_ff <= ST_CANCEL;
               else if (req_kind == KIND_NEW)
                  state_ff <= (req_quantity != 0) ? ST_MATCH : ST_DONE;
               else state_ff <= ST_DONE;
            end
            ST_CANCEL: begin
               if (cancel_hit) begin
                  found_ff <= 1'b1; best_idx_ff <= rd_idx_ff; best_ff <= rd_data;
               end
               if (scan_end) begin
                  if (cancel_hit) valid_ff[rd_idx_ff] <= 1'b0;
                  else if (found_ff) valid_ff[best_idx_ff] <= 1'b0;
                  else status_ff <= STATUS_NO_ID;
                  scan_ff <= '0; found_ff <= 1'b0;
                  if (kind_ff == KIND_MODIFY && left_ff != 0) state_ff <= ST_MATCH;
                  else state_ff <= ST_DONE;
               end
            end
            ST_MATCH: begin
               if (cand_valid && cand_cross && cand_better) begin
                  found_ff <= 1'b1; best_idx_ff <= rd_idx_ff; best_ff <= rd_data;
               end
               if (scan_end) begin
                  if ((cand_valid && cand_cross && cand_better) || found_ff)
                     state_ff <= ST_FILL;
                  else state_ff <= ST_REST;
               end
            end
            ST_FILL: begin
               rsp_valid <= 1'b1; rsp_is_completion <= 1'b0;
               rsp_trade_price <= best_ff.price; rsp_trade_quantity <= take_qty;
               rsp_buy_id <= side_ff ? best_ff.oid : id_ff;
               rsp_sell_id <= side_ff ? id_ff : best_ff.oid;
               rsp_trade_time <= ts_ff; rsp_status <= STATUS_OK; rsp_last <= 1'b0;
               left_ff <= left_ff - take_qty;
               if (best_ff.quantity == take_qty) valid_ff[best_idx_ff] <= 1'b0;
               ntrades_ff <= ntrades_ff + 1'b1;
               after_out_done_ff <= (left_ff == take_qty) || (ntrades_ff == LAST_IDX);
               state_ff <= state_in;
            end
            ST_REST: begin
               if (free_found) begin
                  valid_ff[free_idx] <= 1'b1;
                  arrival_ff <= arrival_ff + 1'b1;
               end else status_ff <= STATUS_BOOK_FULL;
               state_ff <= state_in;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1; rsp_is_completion <= 1'b1;
               rsp_trade_price <= '0; rsp_trade_quantity <= '0;
               rsp_buy_id <= '0; rsp_sell_id <= '0;
               rsp_trade_time <= ts_ff; rsp_status <= status_ff; rsp_last <= 1'b1;
               after_out_done_ff <= 1'b0;
               state_ff <= state_in;
            end
            ST_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               // A trade leads to another scan, to resting the remainder, or to the completion item.
               if (rsp_last) state_ff <= ST_IDLE;
               else if (after_out_done_ff)
                  state_ff <= (left_ff == 0) ? ST_DONE : ST_REST;
               else begin
                  state_ff <= ST_MATCH; scan_ff <= '0; found_ff <= 1'b0;
               end
            end
            default: state_ff <= state_in;
         endcase
      end
   end
endmodule

// File: tb/limit_order_book_matcher_core_test.sv
// Testbench for the limit order book matcher core: directed table, a full-book sweep,
// then random order flow, every result checked against a behavioural book model.
// Depends on lobm_pkg and limit_order_book_matcher_core.
`timescale 1ns / 1ps
module limit_order_book_matcher_core_test;
   import lobm_pkg::*;

   localparam int SLOTS = 32;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int TABLE_ROWS = 15;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] oid;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [63:0] timestamp;
   } order_msg_type;

   typedef struct {
      logic        is_completion;
      logic [31:0] trade_price;
      logic [31:0] trade_quantity;
      logic [31:0] buy_id;
      logic [31:0] sell_id;
      logic [63:0] trade_time;
      logic [1:0]  status;
      logic        last;
   } fill_rec_type;

   typedef struct {
      order_msg_type msg;
      logic        fixed;     // status of completion typed in
      logic [1:0]  fixed_status;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [31:0] req_order_id = '0;
   logic        req_side = 1'b0;
   logic [31:0] req_price = '0;
   logic [31:0] req_quantity = '0;
   logic [63:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_is_completion;
   logic [31:0] rsp_trade_price;
   logic [31:0] rsp_trade_quantity;
   logic [31:0] rsp_buy_id;
   logic [31:0] rsp_sell_id;
   logic [63:0] rsp_trade_time;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   always #5 clock = ~clock;

   limit_order_book_matcher_core #(.ORDER_SLOTS(SLOTS)) u_dut (.*);

   // Book model.
   logic        bk_valid [SLOTS];
   logic [31:0] bk_id [SLOTS];
   logic [31:0] bk_price [SLOTS];
   logic [31:0] bk_qty [SLOTS];
   logic        bk_side [SLOTS];
   logic [63:0] bk_age [SLOTS];
   logic [63:0] bk_next_age;

   fill_rec_type expected_fills[$];
   int  errors = 0;
   int  msgs_sent = 0;
   int  fills_seen = 0;
   int  trades_seen = 0;
   int  idle_cycles = 0;
   bit  hold_rx = 1'b0;
   bit  sending_done = 1'b0;

   task automatic book_apply(input order_msg_type m, input bit use_fixed,
                             input logic [1:0] fixed_status);
      int found;
      int best;
      int n;
      logic [31:0] left;
      logic [31:0] fill;
      logic [1:0]  st;
      fill_rec_type r;
      found = -1;
      n = 0;
      st = STATUS_OK;
      if (m.kind == KIND_CANCEL || m.kind == KIND_MODIFY) begin
         for (int i = 0; i < SLOTS; i++)
            if (bk_valid[i] && bk_id[i] == m.oid &&
                (found < 0 || bk_age[i] < bk_age[found]))
               found = i;
         if (found < 0) st = STATUS_NO_ID;
         else bk_valid[found] = 1'b0;
      end
      if (m.kind == KIND_NEW || m.kind == KIND_MODIFY) begin
         left = m.quantity;
         while (left > 0 && n < SLOTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!bk_valid[i] || bk_side[i] == m.side) continue;
               if (m.side == 1'b0 ? bk_price[i] > m.price : bk_price[i] < m.price)
                  continue;
               if (best < 0) best = i;
               else if ((m.side == 1'b0 ? bk_price[i] < bk_price[best]
                                        : bk_price[i] > bk_price[best]) ||
                        (bk_price[i] == bk_price[best] && bk_age[i] < bk_age[best]))
                  best = i;
            end
            if (best < 0) break;
            fill = left < bk_qty[best] ? left : bk_qty[best];
            r = '{1'b0, bk_price[best], fill,
                  m.side == 1'b0 ? m.oid : bk_id[best],
                  m.side == 1'b0 ? bk_id[best] : m.oid,
                  m.timestamp, STATUS_OK, 1'b0};
            expected_fills.insert(expected_fills.size(), r);
            n++;
            left -= fill;
            bk_qty[best] -= fill;
            if (bk_qty[best] == 0) bk_valid[best] = 1'b0;
         end
         if (left > 0) begin
            found = -1;
            for (int i = 0; i < SLOTS; i++)
               if (!bk_valid[i]) begin
                  found = i;
                  break;
               end
            if (found < 0) st = STATUS_BOOK_FULL;
            else begin
               bk_valid[found] = 1'b1;
               bk_id[found] = m.oid;
               bk_price[found] = m.price;
               bk_qty[found] = left;
               bk_side[found] = m.side;
               bk_age[found] = bk_next_age;
               bk_next_age++;
            end
         end
      end
      // A typed-in status must agree with the model, else the table is wrong.
      if (use_fixed && fixed_status != st) begin
         $display("table row %0d: typed status %0d, model %0d", msgs_sent,
                  fixed_status, st);
         errors++;
      end
      r = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, m.timestamp,
            use_fixed ? fixed_status : st, 1'b1};
      expected_fills.insert(expected_fills.size(), r);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at result %0d: %s got %0h expected %0h", fills_seen,
               what, got, want);
      errors++;
   endtask

   // Sender: holds an item until it is taken; valid drops only for a gap.
   task automatic send_msg(input order_msg_type m, input bit use_fixed,
                           input logic [1:0] fixed_status, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= m.kind;
      req_order_id <= m.oid;
      req_side <= m.side;
      req_price <= m.price;
      req_quantity <= m.quantity;
      req_timestamp <= m.timestamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book_apply(m, use_fixed, fixed_status);
      msgs_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_fills.size() != 0) @(posedge clock);
   endtask

   function automatic order_msg_type rand_msg(input int live_ids);
      order_msg_type m;
      int pick;
      m.kind = $urandom_range(9) < 6 ? KIND_NEW :
               ($urandom_range(3) == 0 ? KIND_MODIFY : KIND_CANCEL);
      if ($urandom_range(30) == 0) m.kind = KIND_SPARE;
      m.oid = $urandom_range(live_ids);
      if ($urandom_range(15) == 0) m.oid = $urandom;
      m.side = 1'($urandom_range(1));
      m.price = 32'd1000 + $urandom_range(12);
      pick = $urandom_range(19);
      if (pick == 0) m.price = $urandom;
      else if (pick == 1) m.price = 32'hFFFF_FFFF - $urandom_range(3);
      m.quantity = $urandom_range(1, 60);
      pick = $urandom_range(19);
      if (pick == 0) m.quantity = $urandom;
      else if (pick == 1) m.quantity = 0;
      m.timestamp = {$urandom, $urandom};
      return m;
   endfunction

   // Receiver: random stalls, and one long hold-off on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rx) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
         end
      end
   end

   // Checker and watchdog.
   always @(posedge clock) begin
      fill_rec_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_fills.size());
            $display("FAILED: results differ");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_fills.size() == 0) begin
               report_mismatch("unexpected result, is_completion",
                               64'(rsp_is_completion), 64'd0);
            end else begin
               e = expected_fills[0];
               expected_fills.delete(0);
               if (rsp_is_completion !== e.is_completion)
                  report_mismatch("is_completion", 64'(rsp_is_completion),
                                  64'(e.is_completion));
               if (rsp_trade_price !== e.trade_price)
                  report_mismatch("trade_price", 64'(rsp_trade_price), 64'(e.trade_price));
               if (rsp_trade_quantity !== e.trade_quantity)
                  report_mismatch("trade_quantity", 64'(rsp_trade_quantity),
                                  64'(e.trade_quantity));
               if (rsp_buy_id !== e.buy_id)
                  report_mismatch("buy_id", 64'(rsp_buy_id), 64'(e.buy_id));
               if (rsp_sell_id !== e.sell_id)
                  report_mismatch("sell_id", 64'(rsp_sell_id), 64'(e.sell_id));
               if (rsp_trade_time !== e.trade_time)
                  report_mismatch("trade_time", rsp_trade_time, e.trade_time);
               if (rsp_status !== e.status)
                  report_mismatch("status", 64'(rsp_status), 64'(e.status));
               if (rsp_last !== e.last)
                  report_mismatch("last", 64'(rsp_last), 64'(e.last));
               if (!e.is_completion) trades_seen++;
            end
            fills_seen++;
         end
      end
   end

   initial begin
      table_row_type rows [TABLE_ROWS];
      order_msg_type m;
      for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
      bk_next_age = '0;
      // Directed rows: kind, id, side, price, qty, time; typed status where plain.
      rows[0] = '{'{KIND_CANCEL, 32'd7, 1'b0, 32'd0, 32'd0, 64'd1}, 1'b1, STATUS_NO_ID};
      rows[1] = '{'{KIND_MODIFY, 32'd8, 1'b1, 32'd100, 32'd5, 64'd2}, 1'b1, STATUS_NO_ID};
      rows[2] = '{'{KIND_NEW, 32'd9, 1'b0, 32'd90, 32'd0, 64'd3}, 1'b1, STATUS_OK};
      rows[3] = '{'{KIND_SPARE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, STATUS_OK};
      rows[4] = '{'{KIND_NEW, 32'd10, 1'b1, 32'd100, 32'd4, 64'd4}, 1'b0, STATUS_OK};
      rows[5] = '{'{KIND_NEW, 32'd11, 1'b1, 32'd100, 32'd6, 64'd5}, 1'b0, STATUS_OK};
      rows[6] = '{'{KIND_NEW, 32'd12, 1'b1, 32'd99, 32'd3, 64'd6}, 1'b0, STATUS_OK};
      rows[7] = '{'{KIND_NEW, 32'd13, 1'b0, 32'd100, 32'd9, 64'd7}, 1'b0, STATUS_OK};
      rows[8] = '{'{KIND_NEW, 32'd14, 1'b0, 32'd50, 32'd5, 64'd8}, 1'b0, STATUS_OK};
      rows[9] = '{'{KIND_NEW, 32'd14, 1'b0, 32'd50, 32'd2, 64'd9}, 1'b0, STATUS_OK};
      rows[10] = '{'{KIND_CANCEL, 32'd14, 1'b0, 32'd0, 32'd0, 64'd10}, 1'b1, STATUS_OK};
      rows[11] = '{'{KIND_NEW, 32'd14, 1'b1, 32'd0, 32'd1, 64'd11}, 1'b0, STATUS_OK};
      rows[12] = '{'{KIND_MODIFY, 32'd11, 1'b1, 32'd60, 32'd3, 64'd12}, 1'b0, STATUS_OK};
      rows[13] = '{'{KIND_NEW, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, STATUS_OK};
      rows[14] = '{'{KIND_NEW, 32'd0, 1'b1, 32'd0, 32'hFFFF_FFFF, 64'd0}, 1'b0, STATUS_OK};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_msg(rows[i].msg, rows[i].fixed, rows[i].fixed_status, $urandom_range(17));
      wait_drained();
      // Fill the book on one side so later remainders are dropped.
      for (int i = 0; i < SLOTS + 3; i++) begin
         m = '{KIND_NEW, 32'd100 + i, 1'b1, 32'd5000 + i, 32'd2, {32'd0, $urandom}};
         send_msg(m, 1'b0, STATUS_OK, $urandom_range(3) == 0 ? 0 : $urandom_range(17));
      end
      m = '{KIND_MODIFY, 32'd999, 1'b1, 32'd1, 32'd1, 64'd77};
      send_msg(m, 1'b1, STATUS_BOOK_FULL, 0);
      // A big buy sweeps the whole full book at once.
      m = '{KIND_NEW, 32'd500, 1'b0, 32'hFFFF_FFF0, 32'd1000, 64'd78};
      send_msg(m, 1'b0, STATUS_OK, 0);
      wait_drained();
      // Hold the receiver off while items keep coming, so the input backs up.
      hold_rx = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rx = 1'b0;
         end
         for (int i = 0; i < 10; i++) send_msg(rand_msg(40), 1'b0, STATUS_OK, 0);
      join
      for (int i = 0; i < 170; i++) begin
         if (i % 60 == 59) wait_drained();
         send_msg(rand_msg(40), 1'b0, STATUS_OK,
                  ($urandom_range(4) == 0) ? 0 : $urandom_range(17));
      end
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Covered %0d messages and %0d results, %0d of them trades,",
               msgs_sent, fills_seen, trades_seen);
      $display("including cancels, modifies, unused kinds and a full book.");
      if (errors == 0 && expected_fills.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/lobm_pkg.sv
rtl/lobm_ram.sv
rtl/limit_order_book_matcher_core.sv
tb/limit_order_book_matcher_core_test.sv
